### rtl/tamao_pkg.sv
// Shared types, codes and helpers for the three-axis moving average block.
`timescale 1ns / 1ps

package tamao_pkg;

    localparam int SAMPLE_W = 16;
    localparam int AXES     = 3;

    // Item function codes carried in s_tuser
    typedef enum logic [2:0] {
        FN_CALIB         = 3'd0,
        FN_RAW           = 3'd1,
        FN_PUSH_MEAN     = 3'd2,
        FN_PUSH_MEAN_OFS = 3'd3,
        FN_MEAN          = 3'd4,
        FN_MEAN_OFS      = 3'd5
    } func_t;

    // What the result stage drives onto the output
    typedef enum logic [1:0] {
        RK_ZERO,
        RK_RAW,
        RK_MEAN,
        RK_MEAN_OFS
    } rkind_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Decoded item entering the ring stage
    typedef struct packed {
        logic   valid;
        logic   wr;
        logic   cal;
        logic   done;
        rkind_t kind;
    } ring_req_t;

    // Item leaving the ring stage for the divider
    typedef struct packed {
        logic   valid;
        rkind_t kind;
        logic   load_ofs;
    } div_req_t;

    function automatic sample_t sat16(input logic signed [18:0] v);
        sample_t r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### rtl/tamao_ring.sv
// Sample ring memory with read-modify-write of the running and calibration sums.
`timescale 1ns / 1ps

module tamao_ring
    import tamao_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  ring_req_t                              req,
    input  logic [$clog2(WINDOW_LEN)-1:0]          slot,
    input  sample_t                                samp [AXES],
    output div_req_t                               dreq,
    output logic signed [SAMPLE_W+$clog2(WINDOW_LEN)-1:0] opnd [AXES]
);

    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int SW      = SAMPLE_W + SLOT_W;
    localparam int ROW_W   = AXES * SAMPLE_W;
    localparam int SUM_MAX = 32767 * WINDOW_LEN;
    localparam int SUM_MIN = -32768 * WINDOW_LEN;

    logic [ROW_W-1:0]      mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] ent_vld_reg;

    logic [ROW_W-1:0]      rd_reg;
    logic                  rd_zero_reg;
    logic                  fwd_reg;
    logic [ROW_W-1:0]      fwd_dat_reg;

    logic                  v1_reg;
    rkind_t                kind1_reg;
    logic                  wr1_reg;
    logic                  cal1_reg;
    logic                  done1_reg;
    logic [SLOT_W-1:0]     slot1_reg;
    logic [ROW_W-1:0]      samp1_reg;

    logic signed [SW-1:0]  sum_reg  [AXES];
    logic signed [SW-1:0]  sum_next [AXES];
    logic signed [SW-1:0]  cal_reg  [AXES];
    logic signed [SW-1:0]  cal_next [AXES];
    sample_t               s_ax     [AXES];
    sample_t               old_ax   [AXES];

    // Ring storage: one write from the update stage, one registered read at accept
    always_ff @(posedge aclk) begin
        if (en && v1_reg && wr1_reg) begin
            mem[slot1_reg] <= samp1_reg;
        end
        if (en && req.valid) begin
            rd_reg <= mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            kind1_reg   <= RK_ZERO;
            wr1_reg     <= 1'b0;
            cal1_reg    <= 1'b0;
            done1_reg   <= 1'b0;
            fwd_reg     <= 1'b0;
            rd_zero_reg <= 1'b1;
            ent_vld_reg <= '0;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= '0;
                cal_reg[a] <= '0;
            end
        end else if (en) begin
            v1_reg    <= req.valid;
            kind1_reg <= req.kind;
            wr1_reg   <= req.wr;
            cal1_reg  <= req.cal;
            done1_reg <= req.done;
            if (req.valid) begin
                // same slot written by the item ahead at this edge: memory still has old data
                fwd_reg     <= v1_reg && wr1_reg && (slot1_reg == slot);
                rd_zero_reg <= !ent_vld_reg[slot];
            end
            if (v1_reg && wr1_reg) begin
                ent_vld_reg[slot1_reg] <= 1'b1;
            end
            if (v1_reg) begin
                for (int a = 0; a < AXES; a++) begin
                    sum_reg[a] <= sum_next[a];
                    if (cal1_reg) begin
                        cal_reg[a] <= done1_reg ? '0 : cal_next[a];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot1_reg   <= slot;
            samp1_reg   <= {samp[2], samp[1], samp[0]};
            fwd_dat_reg <= samp1_reg;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            s_ax[a] = samp1_reg[a*SAMPLE_W +: SAMPLE_W];
            if (fwd_reg) begin
                old_ax[a] = fwd_dat_reg[a*SAMPLE_W +: SAMPLE_W];
            end else if (rd_zero_reg) begin
                old_ax[a] = '0;
            end else begin
                old_ax[a] = rd_reg[a*SAMPLE_W +: SAMPLE_W];
            end
            sum_next[a] = wr1_reg ? (sum_reg[a] + SW'(s_ax[a]) - SW'(old_ax[a])) : sum_reg[a];
            cal_next[a] = cal_reg[a] + SW'(s_ax[a]);
            if (kind1_reg == RK_RAW) begin
                opnd[a] = SW'(s_ax[a]);
            end else if (cal1_reg && done1_reg) begin
                opnd[a] = cal_next[a];
            end else begin
                opnd[a] = sum_next[a];
            end
        end
    end

    assign dreq.valid    = v1_reg;
    assign dreq.kind     = kind1_reg;
    assign dreq.load_ofs = cal1_reg && done1_reg;

`ifndef SYNTHESIS
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_reg[0] <= SUM_MAX) && (sum_reg[0] >= SUM_MIN) &&
        (sum_reg[1] <= SUM_MAX) && (sum_reg[1] >= SUM_MIN) &&
        (sum_reg[2] <= SUM_MAX) && (sum_reg[2] >= SUM_MIN))
        else $error("running sum out of window range");

    a_cal_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v1_reg && cal1_reg && done1_reg) |=>
        (cal_reg[0] == '0) && (cal_reg[1] == '0) && (cal_reg[2] == '0))
        else $error("calibration sums not cleared after offset load");
`endif

endmodule

### rtl/tamao_mean_div.sv
// Divide by window length via reciprocal multiply, offset removal, saturation, output reg.
`timescale 1ns / 1ps

module tamao_mean_div
    import tamao_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  div_req_t                               dreq,
    input  logic signed [SAMPLE_W+$clog2(WINDOW_LEN)-1:0] opnd [AXES],
    output logic                                   res_valid,
    output sample_t                                res [AXES],
    output logic                                   ofs_rdy
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int SW     = SAMPLE_W + SLOT_W;
    localparam int K      = SW + SLOT_W;          // reciprocal scale, exact for |x| < 2**SW
    localparam int RW     = SW + 2;
    localparam int PW     = SW + RW;
    localparam int QW     = SAMPLE_W + 1;         // quotient magnitude up to 32768
    localparam logic [RW-1:0] RECIP = RW'((2**K + WINDOW_LEN - 1) / WINDOW_LEN);

    logic                 v2_reg, ld2_reg;
    rkind_t               kind2_reg;
    logic signed [SW-1:0] opnd2_reg [AXES];

    logic                 v3_reg, ld3_reg;
    rkind_t               kind3_reg;
    logic [AXES-1:0]      neg3_reg;
    logic [PW-1:0]        prod3_reg [AXES];
    sample_t              raw3_reg  [AXES];

    logic                 v4_reg, rdy4_reg;
    sample_t              res4_reg  [AXES];
    sample_t              ofs_reg   [AXES];

    logic [SW-1:0]        mag       [AXES];
    logic [PW-1:0]        prod_next [AXES];
    logic [QW-1:0]        q         [AXES];
    logic signed [QW:0]   qs        [AXES];
    logic signed [QW:0]   mean      [AXES];
    logic signed [18:0]   diff      [AXES];
    sample_t              res_next  [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            mag[a]       = opnd2_reg[a][SW-1] ? SW'(-opnd2_reg[a]) : SW'(opnd2_reg[a]);
            prod_next[a] = PW'(mag[a]) * PW'(RECIP);
            q[a]         = prod3_reg[a][K +: QW];
            qs[a]        = $signed({1'b0, q[a]});
            mean[a]      = neg3_reg[a] ? -qs[a] : qs[a];
            diff[a]      = 19'(mean[a]) - 19'(ofs_reg[a]);
            case (kind3_reg)
                RK_ZERO:     res_next[a] = '0;
                RK_RAW:      res_next[a] = raw3_reg[a];
                RK_MEAN:     res_next[a] = sat16(19'(mean[a]));
                RK_MEAN_OFS: res_next[a] = sat16(diff[a]);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg    <= 1'b0;
            ld2_reg   <= 1'b0;
            kind2_reg <= RK_ZERO;
            v3_reg    <= 1'b0;
            ld3_reg   <= 1'b0;
            kind3_reg <= RK_ZERO;
            v4_reg    <= 1'b0;
            rdy4_reg  <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                ofs_reg[a] <= '0;
            end
        end else if (en) begin
            v2_reg    <= dreq.valid;
            ld2_reg   <= dreq.load_ofs;
            kind2_reg <= dreq.kind;
            v3_reg    <= v2_reg;
            ld3_reg   <= ld2_reg;
            kind3_reg <= kind2_reg;
            v4_reg    <= v3_reg;
            rdy4_reg  <= v3_reg && ld3_reg;
            if (v3_reg && ld3_reg) begin
                for (int a = 0; a < AXES; a++) begin
                    ofs_reg[a] <= mean[a][SAMPLE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                opnd2_reg[a] <= opnd[a];
                neg3_reg[a]  <= opnd2_reg[a][SW-1];
                prod3_reg[a] <= prod_next[a];
                raw3_reg[a]  <= opnd2_reg[a][SAMPLE_W-1:0];
                res4_reg[a]  <= res_next[a];
            end
        end
    end

    assign res_valid = v4_reg;
    assign ofs_rdy   = rdy4_reg;
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            res[a] = res4_reg[a];
        end
    end

`ifndef SYNTHESIS
    a_rdy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && rdy4_reg) |->
        (res4_reg[0] == '0) && (res4_reg[1] == '0) && (res4_reg[2] == '0))
        else $error("offset ready with nonzero result data");

    a_ofs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(en && v3_reg && ld3_reg)) |->
        ($stable(ofs_reg[0]) && $stable(ofs_reg[1]) && $stable(ofs_reg[2])))
        else $error("offset changed without a calibration load");
`endif

endmodule

### rtl/three_axis_moving_average_offset.sv
// Top level: three-axis boxcar moving average with offset calibration.
//
//   channel  direction  tdata (low bit up)                      tuser
//   s_       in         sample_x[15:0] sample_y[31:16]          func[2:0]
//                       sample_z[47:32]
//   m_       out        out_x[15:0] out_y[31:16] out_z[47:32]   offset_ready[0]
//
// One item per cycle while m_ is not stalled; a result reaches m_ through four
// register stages after the edge that accepts its item: ring read, sum update,
// reciprocal multiply, offset/saturate.
// The ring is one memory, read at accept and written from the update stage; a
// write-to-read forward covers back-to-back items on the same slot.
// Reset (aresetn low, synchronous) clears the sums, offsets, slot counters
// and the per-slot valid bits; no clearing pass, items accepted at once.
// A stalled m_ side freezes the whole pipeline; s_tready drops only then.
`timescale 1ns / 1ps

module three_axis_moving_average_offset
    import tamao_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample_x[15:0], sample_y[31:16], sample_z[47:32]
    input  logic [47:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_x[15:0], out_y[31:16], out_z[47:32]
    output logic [47:0] m_tdata,
    // offset_ready[0]
    output logic [0:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int SW     = SAMPLE_W + SLOT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

    logic                 en;
    logic                 accept;
    func_t                fn;
    ring_req_t            req;
    logic [SLOT_W-1:0]    slot;
    sample_t              samp [AXES];
    div_req_t             dreq;
    logic signed [SW-1:0] opnd [AXES];
    sample_t              res  [AXES];
    logic                 ofs_rdy;

    logic [SLOT_W-1:0]    wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]    cal_cnt_reg, cal_cnt_next;

    // whole pipeline moves whenever the output register is free or drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign fn      = func_t'(s_tuser);
    assign samp[0] = s_tdata[15:0];
    assign samp[1] = s_tdata[31:16];
    assign samp[2] = s_tdata[47:32];

    // decode: which slot is touched and what the result stage will do
    always_comb begin
        req.valid    = accept;
        req.wr       = 1'b0;
        req.cal      = 1'b0;
        req.done     = 1'b0;
        req.kind     = RK_ZERO;
        slot         = wr_slot_reg;
        wr_slot_next = wr_slot_reg;
        cal_cnt_next = cal_cnt_reg;
        unique case (fn)
            FN_CALIB: begin
                req.wr       = 1'b1;
                req.cal      = 1'b1;
                req.done     = (cal_cnt_reg == LAST_SLOT);
                slot         = cal_cnt_reg;
                cal_cnt_next = (cal_cnt_reg == LAST_SLOT) ? '0 : cal_cnt_reg + 1'b1;
            end
            FN_RAW: begin
                req.kind = RK_RAW;
            end
            FN_PUSH_MEAN, FN_PUSH_MEAN_OFS: begin
                req.wr       = 1'b1;
                req.kind     = (fn == FN_PUSH_MEAN) ? RK_MEAN : RK_MEAN_OFS;
                wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
            end
            FN_MEAN: begin
                req.kind = RK_MEAN;
            end
            FN_MEAN_OFS: begin
                req.kind = RK_MEAN_OFS;
            end
            default: begin
                // unused codes: no state change, all-zero result
                req.kind = RK_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg <= '0;
            cal_cnt_reg <= '0;
        end else if (accept) begin
            wr_slot_reg <= wr_slot_next;
            cal_cnt_reg <= cal_cnt_next;
        end
    end

    tamao_ring #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .req     (req),
        .slot    (slot),
        .samp    (samp),
        .dreq    (dreq),
        .opnd    (opnd)
    );

    tamao_mean_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .dreq      (dreq),
        .opnd      (opnd),
        .res_valid (m_tvalid),
        .res       (res),
        .ofs_rdy   (ofs_rdy)
    );

    assign m_tdata = {res[2], res[1], res[0]};
    assign m_tuser = ofs_rdy;

`ifndef SYNTHESIS
    a_cal_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (fn == FN_CALIB) && (cal_cnt_reg == LAST_SLOT)) |=> (cal_cnt_reg == '0))
        else $error("calibration count did not wrap after last slot");

    a_slot_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (fn != FN_PUSH_MEAN) && (fn != FN_PUSH_MEAN_OFS)) |=> $stable(wr_slot_reg))
        else $error("write slot moved on a non-push item");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_slot_reg <= LAST_SLOT) && (cal_cnt_reg <= LAST_SLOT))
        else $error("slot counter beyond window");
`endif

endmodule

### test/tb_three_axis_moving_average_offset.sv
// Self-checking testbench for the three-axis moving average / offset calibration block.
`timescale 1ns / 1ps

module tb_three_axis_moving_average_offset
    import tamao_pkg::*;
;

    localparam int WINDOW_LEN = 8;

    // Codes the block decodes as "ignore"
    localparam logic [2:0] FN_UNUSED_6 = 3'd6;
    localparam logic [2:0] FN_UNUSED_7 = 3'd7;

    localparam int ITEM_TARGET = 1550;

    // Idle phases, keyed on items sent (sender) or results taken (receiver)
    localparam int SEND_IDLE_FROM  = 400;
    localparam int SEND_IDLE_TO    = 800;
    localparam int RECV_STALL_FROM = 800;
    localparam int BOTH_FROM       = 1200;
    localparam int HEAVY_PCT       = 63;
    localparam int BOTH_PCT        = 29;

    // Long receiver hold-off: pipeline fills and s_tready must drop
    localparam int HOLD_AT  = 200;
    localparam int HOLD_LEN = 300;
    // Sender waits here until every outstanding result is back
    localparam int DRAIN_AT = 1000;

    // Pipeline is 4 deep; wait on after the last result to catch a stray one
    localparam int TAIL_CYCLES = 20;
    localparam int LIMIT_NS    = 6_000_000;

    typedef enum int {
        SM_RANDOM,
        SM_MAX,
        SM_MIN,
        SM_SMALL
    } samp_mode_t;

    typedef struct {
        logic [2:0] code;
        sample_t    x;
        sample_t    y;
        sample_t    z;
    } accel_item_t;

    typedef struct {
        sample_t out_x;
        sample_t out_y;
        sample_t out_z;
        logic    offset_ready;
    } avg_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    three_axis_moving_average_offset #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    accel_item_t pending_q[$];     // items not yet offered
    avg_result_t expected_q[$];    // predicted results, oldest first
    accel_item_t cur_item;         // item currently on s_
    int          sent_cnt   = 0;
    int          recv_cnt   = 0;
    int          errors     = 0;
    int          hold_cnt   = 0;
    bit          hold_done  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state: mirror of the block after reset
    // ------------------------------------------------------------------
    sample_t     ring     [WINDOW_LEN][AXES];
    longint      win_sum  [AXES];
    longint      cal_sum  [AXES];
    sample_t     axis_ofs [AXES];
    int unsigned wr_slot;
    int unsigned cal_cnt;

    initial begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            for (int a = 0; a < AXES; a++) begin
                ring[i][a] = '0;
            end
        end
        for (int a = 0; a < AXES; a++) begin
            win_sum[a]  = 0;
            cal_sum[a]  = 0;
            axis_ofs[a] = '0;
        end
        wr_slot = 0;
        cal_cnt = 0;
    end

    function automatic sample_t clip16(input longint v);
        sample_t r;
        if (v > 32767) begin
            r = 16'sh7FFF;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = sample_t'(v);
        end
        return r;
    endfunction

    // Replace one ring slot, keeping the window sums in step
    function automatic void ring_write(input int unsigned slot, input sample_t s [AXES]);
        for (int a = 0; a < AXES; a++) begin
            win_sum[a] += longint'(s[a]) - longint'(ring[slot][a]);
            ring[slot][a] = s[a];
        end
    endfunction

    // Advance the predictor by one item and return its result
    function automatic avg_result_t predict_average(input accel_item_t it);
        avg_result_t r;
        sample_t     s   [AXES];
        sample_t     res [AXES];
        longint      m;
        s[0] = it.x;
        s[1] = it.y;
        s[2] = it.z;
        for (int a = 0; a < AXES; a++) begin
            res[a] = '0;
        end
        r.offset_ready = 1'b0;
        case (it.code)
            FN_CALIB: begin
                // calibration fills slots 0..N-1 regardless of the push pointer
                ring_write(cal_cnt, s);
                for (int a = 0; a < AXES; a++) begin
                    cal_sum[a] += longint'(s[a]);
                end
                cal_cnt++;
                if (cal_cnt >= WINDOW_LEN) begin
                    for (int a = 0; a < AXES; a++) begin
                        axis_ofs[a] = sample_t'(cal_sum[a] / WINDOW_LEN);
                        cal_sum[a]  = 0;
                    end
                    cal_cnt        = 0;
                    r.offset_ready = 1'b1;
                end
            end
            FN_RAW: begin
                res = s;
            end
            FN_PUSH_MEAN, FN_PUSH_MEAN_OFS, FN_MEAN, FN_MEAN_OFS: begin
                if (it.code == FN_PUSH_MEAN || it.code == FN_PUSH_MEAN_OFS) begin
                    ring_write(wr_slot, s);
                    wr_slot = (wr_slot + 1 >= WINDOW_LEN) ? 0 : wr_slot + 1;
                end
                for (int a = 0; a < AXES; a++) begin
                    // SV signed division truncates toward zero
                    m = win_sum[a] / WINDOW_LEN;
                    if (it.code == FN_MEAN_OFS || it.code == FN_PUSH_MEAN_OFS) begin
                        m -= longint'(axis_ofs[a]);
                    end
                    res[a] = clip16(m);
                end
            end
            default: begin
                // unused codes: no state change, all-zero result
            end
        endcase
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic sample_t gen_sample(input samp_mode_t md);
        sample_t v;
        case (md)
            SM_MAX:   v = 16'sh7FFF;
            SM_MIN:   v = 16'sh8000;
            SM_SMALL: v = sample_t'(int'($urandom_range(200)) - 100);
            default:  v = sample_t'($urandom_range(16'hFFFF));
        endcase
        return v;
    endfunction

    task automatic add_exact(input logic [2:0] code, input sample_t x, y, z);
        accel_item_t it;
        it.code = code;
        it.x    = x;
        it.y    = y;
        it.z    = z;
        pending_q.push_back(it);
    endtask

    task automatic add_item(input logic [2:0] code, input samp_mode_t md);
        add_exact(code, gen_sample(md), gen_sample(md), gen_sample(md));
    endtask

    task automatic build_stimulus();
        int         pick;
        int         n;
        int         r;
        samp_mode_t md;
        // Directed: calibration on the negative rail, interrupted half way
        for (int k = 0; k < 4; k++) begin
            add_item(FN_CALIB, SM_MIN);
        end
        add_exact(FN_RAW, 16'sh7FFF, 16'sh8000, 16'sh0000);
        for (int k = 0; k < 4; k++) begin
            add_item(FN_CALIB, SM_MIN);
        end
        // offset is now -32768; pushing the positive rail drives mean-offset
        // through the upper saturation point
        for (int k = 0; k < WINDOW_LEN; k++) begin
            add_item(FN_PUSH_MEAN_OFS, SM_MAX);
        end
        add_item(FN_MEAN, SM_RANDOM);
        add_item(FN_MEAN_OFS, SM_RANDOM);
        add_exact(FN_RAW, 16'sh8000, 16'sh7FFF, 16'sh0001);
        add_item(FN_UNUSED_6, SM_RANDOM);
        add_item(FN_UNUSED_7, SM_MAX);
        add_item(FN_PUSH_MEAN, SM_MIN);

        // Random: mostly well-formed calibration runs and push runs
        while (pending_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(99);
            md   = samp_mode_t'($urandom_range(3));
            if (pick < 20) begin
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    if ($urandom_range(9) < 2) begin
                        add_item(3'($urandom_range(5, 1)), samp_mode_t'($urandom_range(3)));
                    end
                    add_item(FN_CALIB, ($urandom_range(9) < 8) ? md : SM_RANDOM);
                end
            end else if (pick < 50) begin
                n = $urandom_range(12, 1);
                for (int k = 0; k < n; k++) begin
                    add_item($urandom_range(1) ? FN_PUSH_MEAN : FN_PUSH_MEAN_OFS,
                             ($urandom_range(9) < 7) ? md : SM_RANDOM);
                end
                n = $urandom_range(2);
                for (int k = 0; k < n; k++) begin
                    add_item($urandom_range(1) ? FN_MEAN : FN_MEAN_OFS, SM_RANDOM);
                end
            end else begin
                r = $urandom_range(19);
                if (r == 18) begin
                    add_item(FN_UNUSED_6, md);
                end else if (r == 19) begin
                    add_item(FN_UNUSED_7, md);
                end else begin
                    add_item(3'(r % 6), md);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, end of run
    // ------------------------------------------------------------------
    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // all items accepted and all results back
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0) begin
            @(posedge aclk);
        end
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_three_axis_moving_average_offset: PASS");
        end else begin
            $display("tb_three_axis_moving_average_offset: FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_three_axis_moving_average_offset: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: one item per handshake from pending_q
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_proc
        int idle_pct;
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_average(cur_item));
                sent_cnt++;
            end
            // valid stays up until the item is taken
            if (!s_tvalid || s_tready) begin
                if (sent_cnt >= BOTH_FROM) begin
                    idle_pct = BOTH_PCT;
                end else if (sent_cnt >= SEND_IDLE_FROM && sent_cnt < SEND_IDLE_TO) begin
                    idle_pct = HEAVY_PCT;
                end else begin
                    idle_pct = 0;
                end
                offer = (pending_q.size() != 0) && ($urandom_range(99) >= idle_pct);
                // drain pause: nothing new until the block is empty
                if (sent_cnt == DRAIN_AT && expected_q.size() != 0) begin
                    offer = 1'b0;
                end
                if (offer) begin
                    cur_item = pending_q.pop_front();
                    s_tdata  <= {cur_item.z, cur_item.y, cur_item.x};
                    s_tuser  <= cur_item.code;
                end
                s_tvalid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor / receiver: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [15:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor_proc
        avg_result_t want;
        int          stall_pct;
        bit          ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item outstanding: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_x", want.out_x, m_tdata[15:0]);
                    check_field("out_y", want.out_y, m_tdata[31:16]);
                    check_field("out_z", want.out_z, m_tdata[47:32]);
                    check_field("offset_ready", {15'd0, want.offset_ready},
                                {15'd0, m_tuser[0]});
                end
                recv_cnt++;
            end
            if (recv_cnt >= BOTH_FROM) begin
                stall_pct = BOTH_PCT;
            end else if (recv_cnt >= RECV_STALL_FROM) begin
                stall_pct = HEAVY_PCT;
            end else begin
                stall_pct = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                ready = 1'b0;
            end else if (!hold_done && recv_cnt >= HOLD_AT) begin
                // long hold-off while the sender keeps offering
                hold_done = 1'b1;
                hold_cnt  = HOLD_LEN;
                ready     = 1'b0;
            end else begin
                ready = ($urandom_range(99) >= stall_pct);
            end
            m_tready <= ready;
        end
    end

endmodule
